/* hw/rtl/rolling_hash_substring_match_top_defines.svh */
// Assertion macros shared by the RTL of the rolling hash matcher.
// Define ASSERT_OFF to compile the checks out.
`ifndef ROLLING_HASH_SUBSTRING_MATCH_TOP_DEFINES_SVH
`define ROLLING_HASH_SUBSTRING_MATCH_TOP_DEFINES_SVH

`ifndef ASSERT_OFF

// Same-cycle implication
`define ASSERT_IMPLIES(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication
`define ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, ck, rn, ante, cons)
`define ASSERT_NEXT(label, ck, rn, ante, cons)

`endif

`endif

/* hw/rtl/rhsm_pkg.sv */
`timescale 1ns / 1ps

package rhsm_pkg;

    // Hash arithmetic
    localparam int unsigned HASH_W = 30;
    localparam int unsigned POS_W  = 32;
    localparam logic [HASH_W-1:0] HASH_MOD    = 30'd1000000009;
    localparam logic [5:0]        HASH_BASE   = 6'd31;
    localparam logic [7:0]        CHAR_OFFSET = 8'd96;

    // Barrett constant floor(2^60 / m)
    localparam logic [30:0] BARRETT_MU = 31'((64'd1 << 60) / 64'(HASH_MOD));

    localparam int unsigned MAX_PATTERN_DEF = 16;

    // Operation codes
    typedef enum logic [1:0] {
        OP_CLEAR   = 2'd0,
        OP_PATTERN = 2'd1,
        OP_TEXT    = 2'd2
    } op_t;

    // Reduction table for base times p, indexed by p[29:22]
    typedef logic [34:0] pow_tbl_t [256];

    function automatic pow_tbl_t build_pow_tbl();
        pow_tbl_t    tbl;
        logic [63:0] top;
        for (int i = 0; i < 256; i++)
        begin
            top    = (64'(i) * 64'(HASH_BASE)) << 22;
            tbl[i] = 35'((top / 64'(HASH_MOD)) * 64'(HASH_MOD));
        end
        return tbl;
    endfunction

    localparam pow_tbl_t POW_TBL = build_pow_tbl();

    // One step of the power sequence: p * base mod m
    function automatic logic [HASH_W-1:0] times_base(input logic [HASH_W-1:0] p);
        logic [34:0] prod;
        logic [30:0] rem;
        prod = {5'b0, p} * {29'b0, HASH_BASE};
        rem  = 31'(prod - POW_TBL[p[29:22]]);
        return (rem >= {1'b0, HASH_MOD}) ? 30'(rem - {1'b0, HASH_MOD}) : rem[29:0];
    endfunction

    function automatic logic [HASH_W-1:0] addmod(input logic [HASH_W-1:0] a,
                                                 input logic [HASH_W-1:0] b);
        logic [30:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return (sum >= {1'b0, HASH_MOD}) ? 30'(sum - {1'b0, HASH_MOD}) : sum[29:0];
    endfunction

    function automatic logic [HASH_W-1:0] submod(input logic [HASH_W-1:0] a,
                                                 input logic [HASH_W-1:0] b);
        logic [30:0] dif;
        dif = (a >= b) ? ({1'b0, a} - {1'b0, b})
                       : ({1'b0, a} + {1'b0, HASH_MOD} - {1'b0, b});
        return dif[29:0];
    endfunction

endpackage

/* hw/rtl/rolling_hash_substring_match_top.sv */
`timescale 1ns / 1ps

// Channel  Dir  Width  Transfer content (low bit first)
// s_axis   in   16     op [1:0], ch [9:2], zero fill
// m_axis   out  40     match [0], position [32:1], overflow [33], zero fill
//
// One transfer per cycle is sustained while results are taken; results leave in order.
// The rate is set by the single-cycle loops: power step, prefix hash accumulate and
// the history ring write with a same-entry forward to its read port.
// rst_n clears all hash, length, count and pointer state; the ring needs no clearing.
// Input is held off only while the output register is full, not taken, and a result
// waits at the end of the pipeline.

`include "rolling_hash_substring_match_top_defines.svh"

module rolling_hash_substring_match_top #(
    parameter int unsigned MAX_PATTERN = rhsm_pkg::MAX_PATTERN_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // op [1:0], ch [9:2]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // match [0], position [32:1], overflow [33]
);

    localparam int unsigned HW     = rhsm_pkg::HASH_W;
    localparam int unsigned PW     = rhsm_pkg::POS_W;
    localparam int unsigned RING_D = MAX_PATTERN + 1;
    localparam int unsigned PTR_W  = $clog2(RING_D);
    localparam int unsigned SUM_W  = PTR_W + 1;
    localparam int unsigned LEN_W  = $clog2(MAX_PATTERN + 1);
    localparam int unsigned FILL_W = $clog2(RING_D + 1);

    typedef struct packed {
        logic [1:0]    op;
        logic          ovf;
        logic [HW-1:0] pw;
    } term_tag_t;

    typedef struct packed {
        logic          elig;
        logic          ovf;
        logic [HW-1:0] window;
        logic [PW-1:0] pos;
    } cmp_tag_t;

    typedef struct packed {
        logic          elig;
        logic          ovf;
        logic [HW-1:0] h_next;
        logic [HW-1:0] ph;
        logic [PW-1:0] pos;
        logic          fwd;
        logic [HW-1:0] fwd_h;
        logic [HW-1:0] fwd_p;
    } c1_t;

    // Pipeline advance
    logic adv;
    logic in_xfer;
    logic [1:0] in_op;
    logic [7:0] in_ch;

    // Front state
    logic [HW-1:0]    run_pow_reg;
    logic [HW-1:0]    pat_pow_reg;
    logic [LEN_W-1:0] front_len_reg;
    logic [HW-1:0]    char_val;
    logic [HW-1:0]    mult_b;
    logic             front_full;
    term_tag_t        front_tag;

    // Accumulate stage
    logic          a_vld;
    logic [HW-1:0] a_res;
    term_tag_t     a_tag;
    logic          acc_go;
    logic          acc_text;

    logic [HW-1:0]     hash_reg;
    logic [HW-1:0]     pat_hash_reg;
    logic [LEN_W-1:0]  pat_len_reg;
    logic [PW-1:0]     count_reg;
    logic [PTR_W-1:0]  ptr_reg;
    logic [FILL_W-1:0] fill_reg;

    logic [HW-1:0]     hash_next;
    logic [PTR_W-1:0]  ptr_next;
    logic [FILL_W-1:0] fill_next;
    logic [SUM_W-1:0]  slot_sum;
    logic [SUM_W-1:0]  slot_wrap;
    logic [PTR_W-1:0]  slot;
    logic              elig;
    c1_t               c1_next;

    // History ring: {prefix hash, power}
    logic [2*HW-1:0] ring_mem [RING_D];
    logic [2*HW-1:0] ring_rd_reg;

    // Compare stage
    logic          c1_vld_reg;
    c1_t           c1_reg;
    logic [HW-1:0] hj;
    logic [HW-1:0] pj;
    cmp_tag_t      c1_tag;

    logic          b_vld;
    logic [HW-1:0] b_res;
    cmp_tag_t      b_tag;

    // Output register
    logic          out_vld_reg;
    logic          out_match_reg;
    logic [PW-1:0] out_pos_reg;
    logic          out_ovf_reg;

    assign in_op   = s_axis_tdata[1:0];
    assign in_ch   = s_axis_tdata[9:2];
    assign adv     = m_axis_tready || !out_vld_reg || !b_vld;
    assign in_xfer = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = adv;

    // Character value and term operands
    always_comb
    begin
        if (in_ch >= rhsm_pkg::CHAR_OFFSET)
        begin
            char_val = {22'b0, in_ch - rhsm_pkg::CHAR_OFFSET};
        end
        else
        begin
            char_val = rhsm_pkg::HASH_MOD - {22'b0, rhsm_pkg::CHAR_OFFSET - in_ch};
        end
        front_full    = (front_len_reg >= LEN_W'(MAX_PATTERN));
        mult_b        = (in_op == rhsm_pkg::OP_TEXT) ? run_pow_reg : pat_pow_reg;
        front_tag.op  = in_op;
        front_tag.ovf = (in_op == rhsm_pkg::OP_PATTERN) && front_full;
        front_tag.pw  = run_pow_reg;
    end

    // Power sequences and pattern length as seen at the input
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_pow_reg   <= HW'(1);
            pat_pow_reg   <= HW'(1);
            front_len_reg <= '0;
        end
        else if (in_xfer)
        begin
            case (in_op)
                rhsm_pkg::OP_CLEAR:
                begin
                    run_pow_reg   <= HW'(1);
                    pat_pow_reg   <= HW'(1);
                    front_len_reg <= '0;
                end
                rhsm_pkg::OP_PATTERN:
                begin
                    if (!front_full)
                    begin
                        pat_pow_reg   <= rhsm_pkg::times_base(pat_pow_reg);
                        front_len_reg <= front_len_reg + LEN_W'(1);
                    end
                end
                rhsm_pkg::OP_TEXT:
                begin
                    run_pow_reg <= rhsm_pkg::times_base(run_pow_reg);
                end
                default:
                begin
                end
            endcase
        end
    end

    // Term v * p^k mod m
    rhsm_mulmod #(
        .TAG_W ($bits(term_tag_t))
    ) u_term_mulmod (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .in_vld  (in_xfer),
        .a       (char_val),
        .b       (mult_b),
        .in_tag  (front_tag),
        .out_vld (a_vld),
        .res     (a_res),
        .out_tag (a_tag)
    );

    assign acc_go   = adv && a_vld;
    assign acc_text = acc_go && (a_tag.op == rhsm_pkg::OP_TEXT);

    // Accumulate, ring pointer and window slot
    always_comb
    begin
        hash_next = rhsm_pkg::addmod(hash_reg, a_res);
        ptr_next  = (ptr_reg == PTR_W'(RING_D - 1)) ? '0 : ptr_reg + PTR_W'(1);
        fill_next = (fill_reg == FILL_W'(RING_D)) ? fill_reg : fill_reg + FILL_W'(1);
        slot_sum  = {1'b0, ptr_next} + SUM_W'(RING_D) - SUM_W'(pat_len_reg);
        slot_wrap = (slot_sum >= SUM_W'(RING_D)) ? slot_sum - SUM_W'(RING_D) : slot_sum;
        slot      = slot_wrap[PTR_W-1:0];
        elig      = (a_tag.op == rhsm_pkg::OP_TEXT) && (pat_len_reg != '0)
                    && (fill_next >= FILL_W'(pat_len_reg));

        c1_next.elig   = elig;
        c1_next.ovf    = (a_tag.op == rhsm_pkg::OP_PATTERN) && a_tag.ovf;
        c1_next.h_next = hash_next;
        c1_next.ph     = pat_hash_reg;
        c1_next.pos    = count_reg + PW'(1) - PW'(pat_len_reg);
        c1_next.fwd    = (slot == ptr_reg);
        c1_next.fwd_h  = hash_reg;
        c1_next.fwd_p  = a_tag.pw;
    end

    // Text and pattern state, updated in transfer order
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg     <= '0;
            pat_hash_reg <= '0;
            pat_len_reg  <= '0;
            count_reg    <= '0;
            ptr_reg      <= '0;
            fill_reg     <= '0;
            c1_vld_reg   <= 1'b0;
        end
        else if (adv)
        begin
            c1_vld_reg <= a_vld;
            if (a_vld)
            begin
                case (a_tag.op)
                    rhsm_pkg::OP_CLEAR:
                    begin
                        hash_reg     <= '0;
                        pat_hash_reg <= '0;
                        pat_len_reg  <= '0;
                        count_reg    <= '0;
                        ptr_reg      <= '0;
                        fill_reg     <= '0;
                    end
                    rhsm_pkg::OP_PATTERN:
                    begin
                        if (!a_tag.ovf)
                        begin
                            pat_hash_reg <= rhsm_pkg::addmod(pat_hash_reg, a_res);
                            pat_len_reg  <= pat_len_reg + LEN_W'(1);
                        end
                    end
                    rhsm_pkg::OP_TEXT:
                    begin
                        hash_reg  <= hash_next;
                        count_reg <= count_reg + PW'(1);
                        ptr_reg   <= ptr_next;
                        fill_reg  <= fill_next;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Ring write and registered read
    always_ff @(posedge clk)
    begin
        if (acc_text)
        begin
            ring_mem[ptr_reg] <= {hash_reg, a_tag.pw};
        end
        if (adv)
        begin
            ring_rd_reg <= ring_mem[slot];
            c1_reg      <= c1_next;
        end
    end

    // Window hash; entry written in the same cycle comes from the forward path
    always_comb
    begin
        hj = c1_reg.fwd ? c1_reg.fwd_h : ring_rd_reg[2*HW-1:HW];
        pj = c1_reg.fwd ? c1_reg.fwd_p : ring_rd_reg[HW-1:0];
        c1_tag.elig   = c1_reg.elig;
        c1_tag.ovf    = c1_reg.ovf;
        c1_tag.window = rhsm_pkg::submod(c1_reg.h_next, hj);
        c1_tag.pos    = c1_reg.pos;
    end

    // Pattern hash scaled by p^start
    rhsm_mulmod #(
        .TAG_W ($bits(cmp_tag_t))
    ) u_scale_mulmod (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .in_vld  (c1_vld_reg),
        .a       (c1_reg.ph),
        .b       (pj),
        .in_tag  (c1_tag),
        .out_vld (b_vld),
        .res     (b_res),
        .out_tag (b_tag)
    );

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (adv && b_vld)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (adv && b_vld)
        begin
            out_match_reg <= b_tag.elig && (b_tag.window == b_res);
            out_pos_reg   <= (b_tag.elig && (b_tag.window == b_res)) ? b_tag.pos : '0;
            out_ovf_reg   <= b_tag.ovf;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {6'b0, out_ovf_reg, out_pos_reg, out_match_reg};

    // Checks; the scaled hash is only defined for windows over written entries
    `ASSERT_IMPLIES(a_state_reduced, clk, rst_n, 1'b1,
        run_pow_reg < rhsm_pkg::HASH_MOD && pat_pow_reg < rhsm_pkg::HASH_MOD &&
        hash_reg < rhsm_pkg::HASH_MOD && pat_hash_reg < rhsm_pkg::HASH_MOD)
    `ASSERT_IMPLIES(a_ready_only_on_stall, clk, rst_n, !s_axis_tready,
        out_vld_reg && !m_axis_tready && b_vld)
    `ASSERT_NEXT(a_fwd_for_single_char, clk, rst_n,
        acc_text && pat_len_reg == LEN_W'(1), c1_reg.fwd)
    `ASSERT_IMPLIES(a_scaled_reduced, clk, rst_n, b_vld && b_tag.elig,
        b_res < rhsm_pkg::HASH_MOD)
    `ASSERT_IMPLIES(a_len_within_cap, clk, rst_n, 1'b1,
        pat_len_reg <= LEN_W'(MAX_PATTERN) && front_len_reg <= LEN_W'(MAX_PATTERN))

endmodule

/* hw/rtl/rhsm_mulmod.sv */
`timescale 1ns / 1ps

// Pipelined a * b mod m, Barrett reduction, five register stages.
// A tag travels alongside each operand pair.
module rhsm_mulmod #(
    parameter int unsigned TAG_W = rhsm_pkg::POS_W
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_vld,
    input  logic [rhsm_pkg::HASH_W-1:0] a,
    input  logic [rhsm_pkg::HASH_W-1:0] b,
    input  logic [TAG_W-1:0]            in_tag,
    output logic                        out_vld,
    output logic [rhsm_pkg::HASH_W-1:0] res,
    output logic [TAG_W-1:0]            out_tag
);

    localparam int unsigned STAGES = 5;

    logic [STAGES-1:0] vld_reg;
    logic [TAG_W-1:0]  tag_reg [STAGES];

    logic [59:0] prod_reg;
    logic [61:0] q2_reg;
    logic [31:0] x2_reg;
    logic [31:0] qm_reg;
    logic [31:0] x3_reg;
    logic [31:0] r4_reg;
    logic [rhsm_pkg::HASH_W-1:0] res_reg;

    logic [59:0] prod_next;
    logic [61:0] q2_next;
    logic [60:0] qm_full;
    logic [31:0] r4_next;
    logic [31:0] mod_x1;
    logic [31:0] mod_x2;
    logic [rhsm_pkg::HASH_W-1:0] res_next;

    // Stage arithmetic
    always_comb
    begin
        prod_next = {30'b0, a} * {30'b0, b};
        q2_next   = {31'b0, prod_reg[59:29]} * {31'b0, rhsm_pkg::BARRETT_MU};
        qm_full   = {30'b0, q2_reg[61:31]} * {31'b0, rhsm_pkg::HASH_MOD};
        r4_next   = x3_reg - qm_reg;
        mod_x1    = {2'b0, rhsm_pkg::HASH_MOD};
        mod_x2    = {1'b0, rhsm_pkg::HASH_MOD, 1'b0};
        if (r4_reg >= mod_x2)
        begin
            res_next = 30'(r4_reg - mod_x2);
        end
        else if (r4_reg >= mod_x1)
        begin
            res_next = 30'(r4_reg - mod_x1);
        end
        else
        begin
            res_next = r4_reg[29:0];
        end
    end

    // Valid shift line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[STAGES-2:0], in_vld};
        end
    end

    // Datapath and tags
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg   <= prod_next;
            q2_reg     <= q2_next;
            x2_reg     <= prod_reg[31:0];
            qm_reg     <= qm_full[31:0];
            x3_reg     <= x2_reg;
            r4_reg     <= r4_next;
            res_reg    <= res_next;
            tag_reg[0] <= in_tag;
            for (int i = 1; i < STAGES; i++)
            begin
                tag_reg[i] <= tag_reg[i-1];
            end
        end
    end

    assign out_vld = vld_reg[STAGES-1];
    assign out_tag = tag_reg[STAGES-1];
    assign res     = res_reg;

endmodule

/* bench/rolling_hash_substring_match_top_tb.sv */
`timescale 1ns / 1ps

module rolling_hash_substring_match_top_tb;

    localparam int          RANDOM_ITEMS = 850;
    localparam int          LIMIT_CYCLES = 400000;
    localparam int          DRAIN_CYCLES = 40;
    localparam int          LONG_HOLD    = 400;
    localparam logic [1:0]  OP_UNUSED    = 2'd3;
    localparam logic [7:0]  CH_A         = 8'h61;

    // One result of the matcher
    typedef struct packed {
        logic        match;
        logic [31:0] position;
        logic        overflow;
    } match_result_t;

    // Rolling hash predictor and store of expected results
    class rk_match_scoreboard;
        localparam longint unsigned MOD_M = 64'd1000000009;
        localparam int unsigned     BASE  = 31;
        localparam int unsigned     CAP   = 16;
        localparam int unsigned     RING  = CAP + 1;

        logic [29:0]   pat_hash;
        int unsigned   pat_len;
        logic [29:0]   pat_pow;
        logic [29:0]   text_pow;
        logic [29:0]   text_hash;
        logic [29:0]   hash_ring [RING];
        logic [29:0]   pow_ring [RING];
        int unsigned   ring_wr;
        int unsigned   ring_fill;
        logic [31:0]   text_count;
        match_result_t expected_hits [$];
        int            errors;

        function new();
            errors = 0;
            restart();
        endfunction

        function void restart();
            pat_hash   = '0;
            pat_len    = 0;
            pat_pow    = 30'd1;
            text_pow   = 30'd1;
            text_hash  = '0;
            ring_wr    = 0;
            ring_fill  = 0;
            text_count = '0;
            for (int i = 0; i < RING; i++)
            begin
                hash_ring[i] = '0;
                pow_ring[i]  = '0;
            end
        endfunction

        function logic [29:0] mul_m(logic [29:0] a, logic [29:0] b);
            return 30'((64'(a) * 64'(b)) % MOD_M);
        endfunction

        function logic [29:0] add_m(logic [29:0] a, logic [29:0] b);
            return 30'((64'(a) + 64'(b)) % MOD_M);
        endfunction

        // Byte mapped to (byte - 96) mod m
        function logic [29:0] byte_value(logic [7:0] ch);
            if (ch >= 8'd96)
                return 30'(ch - 8'd96);
            return 30'(MOD_M - 64'(8'd96 - ch));
        endfunction

        function int pending();
            return expected_hits.size();
        endfunction

        // Accepted input transfer: advance state and queue its result
        function void note_input(logic [1:0] op, logic [7:0] ch);
            match_result_t res;
            logic [29:0]   v;
            logic [29:0]   window;
            logic [29:0]   scaled;
            int unsigned   slot;
            res = '0;
            v   = byte_value(ch);
            if (op == rhsm_pkg::OP_CLEAR)
                restart();
            else if (op == rhsm_pkg::OP_PATTERN)
            begin
                if (pat_len >= CAP)
                    res.overflow = 1'b1;
                else
                begin
                    pat_hash = add_m(pat_hash, mul_m(v, pat_pow));
                    pat_pow  = mul_m(pat_pow, 30'(BASE));
                    pat_len++;
                end
            end
            else if (op == rhsm_pkg::OP_TEXT)
            begin
                hash_ring[ring_wr] = text_hash;
                pow_ring[ring_wr]  = text_pow;
                ring_wr = (ring_wr + 1) % RING;
                if (ring_fill < RING)
                    ring_fill++;
                text_hash  = add_m(text_hash, mul_m(v, text_pow));
                text_pow   = mul_m(text_pow, 30'(BASE));
                text_count = text_count + 32'd1;
                if (pat_len != 0 && ring_fill >= pat_len)
                begin
                    slot   = (ring_wr + RING - pat_len) % RING;
                    window = add_m(text_hash, 30'(MOD_M - 64'(hash_ring[slot])));
                    scaled = mul_m(pat_hash, pow_ring[slot]);
                    if (window == scaled)
                    begin
                        res.match    = 1'b1;
                        res.position = text_count - 32'(pat_len);
                    end
                end
            end
            expected_hits = {expected_hits, res};
        endfunction

        // Accepted output transfer: compare with the oldest expectation
        function void check_result(logic [39:0] data);
            match_result_t want;
            match_result_t got;
            got.match    = data[0];
            got.position = data[32:1];
            got.overflow = data[33];
            if (expected_hits.size() == 0)
            begin
                $display("%0t: unexpected result, actual %h", $time, data);
                errors++;
                return;
            end
            want = expected_hits.pop_front();
            if (got.match !== want.match)
            begin
                $display("%0t: match expected %0d actual %0d", $time, want.match, got.match);
                errors++;
            end
            if (got.position !== want.position)
            begin
                $display("%0t: position expected %0d actual %0d",
                         $time, want.position, got.position);
                errors++;
            end
            if (got.overflow !== want.overflow)
            begin
                $display("%0t: overflow expected %0d actual %0d",
                         $time, want.overflow, got.overflow);
                errors++;
            end
        endfunction
    endclass

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;

    rk_match_scoreboard board = new();

    int          cycles      = 0;
    int          rx_cycle    = 0;
    int          hold_left   = 0;
    logic        hold_request = 1'b0;
    logic        hold_done   = 1'b0;
    int          burst_left  = 0;
    int          items_sent  = 0;
    logic [7:0]  pattern_bytes [$];

    rolling_hash_substring_match_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Receiver: long hold once on request, otherwise a rotating stall pattern
    always @(posedge clk)
    begin
        rx_cycle++;
        if (hold_request && !hold_done)
        begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            case (rx_cycle / 128 % 4)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= 1'($urandom_range(0, 1));
                2:       m_axis_tready <= (rx_cycle % 4 == 0);
                default: m_axis_tready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // Output monitor
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tdata);
    end

    // Offer one transfer, wait for acceptance, then maybe idle for a gap
    task automatic send_item(input logic [1:0] op, input logic [7:0] ch);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, ch, op};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        board.note_input(op, ch);
        if (op != OP_UNUSED)
            items_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 30);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Stop offering and wait until every expected result has come
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    task automatic add_pattern_byte(input logic [7:0] ch);
        pattern_bytes = {pattern_bytes, ch};
        send_item(rhsm_pkg::OP_PATTERN, ch);
    endtask

    function automatic logic [7:0] pick_byte(int alphabet);
        case (alphabet)
            0:       return CH_A + 8'($urandom_range(0, 1));
            1:       return 8'h60 + 8'($urandom_range(0, 2));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // One sequence of an optional clear, pattern and text with embedded copies of the pattern
    task automatic run_sequence();
        int plen;
        int tlen;
        int alphabet;
        int used;
        alphabet = $urandom_range(0, 5);
        if (alphabet > 2)
            alphabet = 0;
        if ($urandom_range(0, 9) < 7)
        begin
            send_item(rhsm_pkg::OP_CLEAR, 8'($urandom_range(0, 255)));
            pattern_bytes.delete();
        end
        plen = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 19) : $urandom_range(1, 5);
        for (int i = 0; i < plen; i++)
            add_pattern_byte(pick_byte(alphabet));
        tlen = $urandom_range(4, 40);
        for (int t = 0; t < tlen; t++)
        begin
            if ($urandom_range(0, 3) == 0 && pattern_bytes.size() > 0)
            begin
                used = (pattern_bytes.size() > 16) ? 16 : pattern_bytes.size();
                for (int k = 0; k < used; k++)
                    send_item(rhsm_pkg::OP_TEXT, pattern_bytes[k]);
            end
            else if ($urandom_range(0, 19) == 0)
                add_pattern_byte(pick_byte(alphabet));
            else
                send_item(rhsm_pkg::OP_TEXT, pick_byte(alphabet));
        end
    endtask

    initial
    begin
        int seq_count;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: unused op, empty pattern, basic hits, late append, extremes
        send_item(OP_UNUSED, 8'hFF);
        send_item(rhsm_pkg::OP_TEXT, CH_A);
        send_item(rhsm_pkg::OP_CLEAR, 8'h00);
        send_item(rhsm_pkg::OP_PATTERN, CH_A);
        send_item(rhsm_pkg::OP_PATTERN, CH_A + 8'd1);
        send_item(rhsm_pkg::OP_TEXT, CH_A);
        send_item(rhsm_pkg::OP_TEXT, CH_A + 8'd1);
        send_item(rhsm_pkg::OP_TEXT, CH_A);
        send_item(rhsm_pkg::OP_TEXT, CH_A + 8'd1);
        send_item(rhsm_pkg::OP_PATTERN, CH_A + 8'd2);
        send_item(rhsm_pkg::OP_TEXT, CH_A);
        send_item(rhsm_pkg::OP_TEXT, CH_A + 8'd1);
        send_item(rhsm_pkg::OP_TEXT, CH_A + 8'd2);
        send_item(rhsm_pkg::OP_CLEAR, 8'hFF);
        send_item(rhsm_pkg::OP_PATTERN, 8'h00);
        send_item(rhsm_pkg::OP_PATTERN, 8'hFF);
        send_item(rhsm_pkg::OP_TEXT, 8'h60);
        send_item(rhsm_pkg::OP_TEXT, 8'h00);
        send_item(rhsm_pkg::OP_TEXT, 8'hFF);
        send_item(OP_UNUSED, 8'h00);
        send_item(rhsm_pkg::OP_CLEAR, 8'h00);

        // Random: mostly well-formed sequences, some noise
        seq_count = 0;
        pattern_bytes.delete();
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            seq_count++;
            if (seq_count == 4)
                hold_request <= 1'b1;
            if (seq_count == 12)
                wait_drained();
            if ($urandom_range(0, 4) == 0)
            begin
                repeat ($urandom_range(1, 5))
                    send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
                pattern_bytes.delete();
            end
            else
                run_sequence();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
